// ----- sv/clcd_pkg.sv -----
package clcd_pkg;

  // Display geometry and address space.
  localparam int unsigned COLUMNS = 20;
  localparam int unsigned CELLS   = 80;
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW1_BASE = ADDR_W'(64);
  localparam logic [ADDR_W-1:0] ROW2_BASE = ADDR_W'(20);
  localparam logic [ADDR_W-1:0] ROW3_BASE = ADDR_W'(84);

  // Character code that the clear instruction fills in.
  localparam logic [CHAR_W-1:0] BLANK_CODE = CHAR_W'(32);

  // Item kinds and pin numbers.
  localparam logic       CMD_PIN       = 1'b0;
  localparam logic       CMD_READ      = 1'b1;
  localparam logic [3:0] PIN_DATA_LAST = 4'd7;
  localparam logic [3:0] PIN_RS        = 4'd8;
  localparam logic [3:0] PIN_RW        = 4'd9;
  localparam logic [3:0] PIN_EN        = 4'd10;
  localparam logic [3:0] PIN_LIGHT     = 4'd11;

  // Status that every result carries.
  typedef struct packed {
    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] first_column;
    logic              display_enabled;
    logic              cursor_shown;
    logic              cursor_blinks;
    logic              light_on;
    logic              two_line_mode;
    logic              tall_font;
    logic              wide_bus;
  } clcd_status_t;

  // Side effects of one pin event, handed from the executor to the sequencer.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              clear;
    logic              redraw;
  } clcd_action_t;

  // One result item.
  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    clcd_status_t      status;
    logic              redraw;
  } clcd_result_t;

  // Address step with wrap inside the character store.
  function automatic logic [ADDR_W-1:0] wrap_up(input logic [ADDR_W-1:0] v);
    return (v >= LAST_CELL) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_down(input logic [ADDR_W-1:0] v);
    return (v == '0 || v > LAST_CELL) ? LAST_CELL : v - 1'b1;
  endfunction

endpackage

// ----- sv/clcd_if.sv -----
// Request channel: one pin event or one cell read per transaction.
interface clcd_req_if import clcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [3:0]        pin;
  logic              level;
  logic [ADDR_W-1:0] cell_index;

  modport source (output valid, cmd, pin, level, cell_index, input ready);
  modport sink   (input valid, cmd, pin, level, cell_index, output ready);
endinterface

// Response channel: one result per request transaction.
interface clcd_rsp_if import clcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] read_char;
  logic [ADDR_W-1:0] cursor_addr;
  logic [ADDR_W-1:0] first_column;
  logic              display_enabled;
  logic              cursor_shown;
  logic              cursor_blinks;
  logic              light_on;
  logic              two_line_mode;
  logic              tall_font;
  logic              wide_bus;
  logic              redraw;

  modport source (output valid, read_char, cursor_addr, first_column, display_enabled,
                  cursor_shown, cursor_blinks, light_on, two_line_mode, tall_font,
                  wide_bus, redraw, input ready);
  modport sink   (input valid, read_char, cursor_addr, first_column, display_enabled,
                  cursor_shown, cursor_blinks, light_on, two_line_mode, tall_font,
                  wide_bus, redraw, output ready);
endinterface

// ----- sv/clcd_ram.sv -----
// Simple dual-port RAM with one write port and a registered read port.
module clcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/clcd_exec.sv -----
// Pin event executor: holds the controller registers, assembles bytes and
// decodes instructions. Character store traffic leaves as an action.
module clcd_exec import clcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         ev_valid,
  input  logic [3:0]   pin,
  input  logic         level,
  output clcd_status_t sts,
  output clcd_action_t act
);

  logic [CHAR_W-1:0] latched, latched_next;
  logic              rs_cmd, rs_cmd_next;
  logic              rw_read, rw_read_next;
  logic              low_phase, low_phase_next;
  logic              move_inc, move_inc_next;
  logic              shift_en, shift_en_next;
  logic              ddram_sel, ddram_sel_next;
  clcd_status_t      st, st_next;

  logic              fire;
  logic [2:0]        bit_idx;
  logic              use_bit;
  logic [ADDR_W-1:0] a;

  // Next register values for one event.
  always_comb begin
    latched_next   = latched;
    rs_cmd_next    = rs_cmd;
    rw_read_next   = rw_read;
    low_phase_next = low_phase;
    move_inc_next  = move_inc;
    shift_en_next  = shift_en;
    ddram_sel_next = ddram_sel;
    st_next        = st;
    act            = '0;
    fire           = 1'b0;
    bit_idx        = pin[2:0];
    use_bit        = 1'b1;
    a              = latched[ADDR_W-1:0];

    if (ev_valid) begin
      if (pin <= PIN_DATA_LAST) begin
        // In the low nibble phase pins 4-7 carry bits 0-3.
        if (!st.wide_bus && low_phase) begin
          use_bit = pin[2];
          bit_idx = {1'b0, pin[1:0]};
        end
        if (!rw_read && use_bit) begin
          latched_next[bit_idx] = level;
        end
      end else if (pin == PIN_RS) begin
        rs_cmd_next = ~level;
      end else if (pin == PIN_RW) begin
        rw_read_next = level;
      end else if (pin == PIN_EN) begin
        if (!level && !rw_read) begin
          if (st.wide_bus) begin
            fire = 1'b1;
          end else begin
            low_phase_next = ~low_phase;
            fire           = low_phase;
          end
        end
      end else if (pin == PIN_LIGHT) begin
        st_next.light_on = level;
        act.redraw       = 1'b1;
      end
    end

    // Execute the assembled byte as an instruction or a character write.
    if (fire) begin
      if (rs_cmd) begin
        if (latched[7]) begin
          if (a < COLS_A) begin
            st_next.cursor_addr = a;
          end else if (a >= ROW1_BASE && a < ROW1_BASE + COLS_A) begin
            st_next.cursor_addr = a - ROW1_BASE + COLS_A;
          end else if (a >= ROW2_BASE && a < ROW2_BASE + COLS_A) begin
            st_next.cursor_addr = a - ROW2_BASE + ADDR_W'(2 * COLUMNS);
          end else if (a >= ROW3_BASE && a < ROW3_BASE + COLS_A) begin
            st_next.cursor_addr = a - ROW3_BASE + ADDR_W'(3 * COLUMNS);
          end
          ddram_sel_next = 1'b1;
        end else if (latched[6]) begin
          st_next.cursor_addr = {1'b0, latched[5:0]};
          ddram_sel_next      = 1'b0;
        end else if (latched[5]) begin
          st_next.wide_bus      = latched[4];
          st_next.two_line_mode = latched[3];
          st_next.tall_font     = latched[2];
        end else if (latched[4]) begin
          if (latched[3]) begin
            st_next.first_column = latched[2] ? wrap_down(st.first_column)
                                              : wrap_up(st.first_column);
          end
        end else if (latched[3]) begin
          st_next.display_enabled = latched[2];
          st_next.cursor_shown    = latched[1];
          st_next.cursor_blinks   = latched[0];
        end else if (latched[2]) begin
          move_inc_next = latched[1];
          shift_en_next = latched[0];
        end else if (latched[1]) begin
          st_next.cursor_addr  = '0;
          st_next.first_column = '0;
          ddram_sel_next       = 1'b1;
        end else if (latched[0]) begin
          st_next.cursor_addr  = '0;
          st_next.first_column = '0;
          move_inc_next        = 1'b1;
          ddram_sel_next       = 1'b1;
          act.clear            = 1'b1;
        end
      end else if (ddram_sel) begin
        act.we              = st.cursor_addr <= LAST_CELL;
        act.waddr           = st.cursor_addr;
        act.wdata           = latched;
        act.redraw          = 1'b1;
        st_next.cursor_addr = wrap_up(st.cursor_addr);
        if (shift_en) begin
          st_next.first_column = move_inc ? wrap_up(st.first_column)
                                          : wrap_down(st.first_column);
        end
      end
    end
  end

  assign sts = st_next;

  // Controller registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      latched   <= '0;
      rs_cmd    <= 1'b0;
      rw_read   <= 1'b0;
      low_phase <= 1'b0;
      move_inc  <= 1'b0;
      shift_en  <= 1'b0;
      ddram_sel <= 1'b0;
      st        <= '0;
    end else begin
      latched   <= latched_next;
      rs_cmd    <= rs_cmd_next;
      rw_read   <= rw_read_next;
      low_phase <= low_phase_next;
      move_inc  <= move_inc_next;
      shift_en  <= shift_en_next;
      ddram_sel <= ddram_sel_next;
      st        <= st_next;
    end
  end

endmodule

// ----- sv/character_lcd_controller.sv -----
// Character LCD controller, pin-level model.
// The req channel carries one transaction per pin event (cmd 0: pin, level)
// or per cell read (cmd 1: cell_index). The rsp channel returns exactly one
// result per request: the cell's character code for a read (0 for a pin
// event or an index past the last cell) and the controller status after it.
// A pin event result passes through the result stage and the rsp register;
// a read first waits in ST_READ for the registered read of the character
// store RAM. No new request is taken until the last result leaves the stage.
// The clear instruction fills all 80 cells with blanks, one cell per cycle,
// so req.ready stays low until that pass ends. Reset starts the same pass
// with zeros; no request is taken until it ends.
// A result stage sits in front of the rsp register, so when the receiver
// stalls one more request is still taken and its result waits there; after
// that req.ready stays low until rsp.ready returns.
module character_lcd_controller import clcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  clcd_req_if.sink          req,
  clcd_rsp_if.source        rsp
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] sweep_addr;
  logic [CHAR_W-1:0] sweep_fill;
  logic              read_hit;
  logic              stage_valid;
  clcd_result_t      stage;
  logic              rsp_valid;
  clcd_result_t      rsp_q;

  logic              accept;
  logic              ev_valid;
  clcd_status_t      sts;
  clcd_action_t      act;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [CHAR_W-1:0] ram_rdata;

  assign req.ready = (state == ST_IDLE) && !stage_valid;
  assign accept    = req.valid && req.ready;
  assign ev_valid  = accept && (req.cmd == CMD_PIN);

  clcd_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (ev_valid),
    .pin      (req.pin),
    .level    (req.level),
    .sts      (sts),
    .act      (act)
  );

  // The fill pass owns the write port; otherwise character writes use it.
  assign ram_we    = (state == ST_SWEEP) ? 1'b1       : act.we;
  assign ram_waddr = (state == ST_SWEEP) ? sweep_addr : act.waddr;
  assign ram_wdata = (state == ST_SWEEP) ? sweep_fill : act.wdata;
  assign ram_re    = accept && (req.cmd == CMD_READ) && (req.cell_index <= LAST_CELL);

  clcd_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (req.cell_index),
    .rdata (ram_rdata)
  );

  // Sequencer, result stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      sweep_fill  <= '0;
      stage_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == LAST_CELL) begin
            sweep_addr <= '0;
            state      <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            stage.status    <= sts;
            stage.read_char <= '0;
            stage.redraw    <= act.redraw;
            read_hit        <= ram_re;
            if (req.cmd == CMD_READ) begin
              state <= ST_READ;
            end else begin
              stage_valid <= 1'b1;
              if (act.clear) begin
                sweep_fill <= BLANK_CODE;
                sweep_addr <= '0;
                state      <= ST_SWEEP;
              end
            end
          end
        end
        ST_READ: begin
          stage.read_char <= read_hit ? ram_rdata : '0;
          stage_valid     <= 1'b1;
          state           <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Move the staged result on when the output register is free.
      if (stage_valid && (!rsp_valid || rsp.ready)) begin
        rsp_q       <= stage;
        rsp_valid   <= 1'b1;
        stage_valid <= 1'b0;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.read_char       = rsp_q.read_char;
  assign rsp.cursor_addr     = rsp_q.status.cursor_addr;
  assign rsp.first_column    = rsp_q.status.first_column;
  assign rsp.display_enabled = rsp_q.status.display_enabled;
  assign rsp.cursor_shown    = rsp_q.status.cursor_shown;
  assign rsp.cursor_blinks   = rsp_q.status.cursor_blinks;
  assign rsp.light_on        = rsp_q.status.light_on;
  assign rsp.two_line_mode   = rsp_q.status.two_line_mode;
  assign rsp.tall_font       = rsp_q.status.tall_font;
  assign rsp.wide_bus        = rsp_q.status.wide_bus;
  assign rsp.redraw          = rsp_q.redraw;

  // A clear instruction starts the blank fill pass.
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    (accept && act.clear) |=> (state == ST_SWEEP && sweep_addr == '0))
    else $error("clear did not start the fill pass");

  // A read transaction waits in ST_READ for the RAM before its result is staged.
  a_read_stage: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == CMD_READ) |=> (state == ST_READ && !stage_valid))
    else $error("read did not wait for RAM data");

  // The fill pass ends after the last cell.
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && sweep_addr == LAST_CELL) |=> (state == ST_IDLE))
    else $error("fill pass did not end at the last cell");

  // The address counter and the shift offset never leave the character store.
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (sts.cursor_addr <= LAST_CELL) && (sts.first_column <= LAST_CELL))
    else $error("address counter or shift offset out of range");

endmodule
